FILE: rtl/ede_pkg.sv
// Shared types and constants for the edit distance engine.
// No dependencies; used by every file of the block.
`timescale 1ns / 1ps
`default_nettype none

package ede_pkg;

  // Longest source or target string
  localparam int MAX_LEN = 64;
  // Width of a cost value and of the length counters (holds 0..MAX_LEN)
  localparam int COST_W  = $clog2(MAX_LEN + 1);
  localparam int CHAR_W  = 8;
  localparam int DIST_W  = 7;
  localparam int DIST_MAX = 127;

  // Request codes carried in req_type
  typedef enum logic [1:0] {
    REQ_SOURCE = 2'd0,
    REQ_TARGET = 2'd1,
    REQ_FINISH = 2'd2
  } req_code_t;

  // Input item
  typedef struct packed {
    logic [1:0]        req_type;
    logic [CHAR_W-1:0] char_in;
  } ede_req_t;

  // Result item
  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              error;
  } ede_res_t;

  // Data handed from one cell to the next along the row
  typedef struct packed {
    logic              valid;
    logic [CHAR_W-1:0] ch;
    logic [COST_W-1:0] new_cost;
    logic [COST_W-1:0] old_cost;
  } ede_link_t;

endpackage

`default_nettype wire

FILE: rtl/ede_cell.sv
// One cell of the distance row: holds one source byte and its column cost.
// Depends on ede_pkg for the link struct and widths.
`timescale 1ns / 1ps
`default_nettype none

module ede_cell (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      clr,
  input  wire logic [ede_pkg::COST_W-1:0] cell_idx,
  input  wire logic                      load_en,
  input  wire logic [ede_pkg::CHAR_W-1:0] load_char,
  input  wire ede_pkg::ede_link_t         link_in,
  output ede_pkg::ede_link_t              link_out,
  output logic [ede_pkg::COST_W-1:0]      cost
);

  logic                       active;
  logic [ede_pkg::CHAR_W-1:0] src_char;
  logic [ede_pkg::COST_W-1:0] cost_next;
  logic [ede_pkg::COST_W-1:0] min_ab;
  logic [ede_pkg::COST_W-1:0] min_abc;

  // Pick the cheapest of delete, insert and replace, or the diagonal cost on a match
  always_comb begin
    min_ab    = (cost < link_in.new_cost) ? cost : link_in.new_cost;
    min_abc   = (min_ab < link_in.old_cost) ? min_ab : link_in.old_cost;
    if (!active) begin
      // Past the end of the source: pass the last real cost straight on
      cost_next = link_in.new_cost;
    end else if (src_char == link_in.ch) begin
      cost_next = link_in.old_cost;
    end else begin
      cost_next = min_abc + ede_pkg::COST_W'(1);
    end
  end

  // Hold the source byte once loaded
  always_ff @(posedge clk) begin
    if (load_en) begin
      src_char <= load_char;
    end
  end

  // Update the cost as each target byte passes and hand it on
  always_ff @(posedge clk) begin
    link_out.ch       <= link_in.ch;
    link_out.new_cost <= cost_next;
    link_out.old_cost <= cost;
    if (rst || clr) begin
      active         <= 1'b0;
      cost           <= cell_idx;
      link_out.valid <= 1'b0;
    end else begin
      if (load_en) begin
        active <= 1'b1;
      end
      link_out.valid <= link_in.valid;
      if (link_in.valid) begin
        cost <= cost_next;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/edit_distance_engine.sv
// Top level of the edit distance engine: request decode, row of cells, result register.
// Depends on ede_pkg and ede_cell.
`timescale 1ns / 1ps
`default_nettype none

// Levenshtein distance between a source and a target byte string, each up to
// MAX_LEN bytes. Source and target bytes are taken one per cycle; each target
// byte passes an input register and then sweeps across a row of MAX_LEN cells
// one cell per cycle, so target bytes follow each other back to back. A finish
// item is held off after the last target byte was taken, while that byte
// crosses the input register and the whole row, and until the result register
// is free; its result appears in the next cycle and the block is cleared in
// the same edge, with no further clearing pass. Overlong strings and source
// bytes after target bytes set a sticky error flag reported with the next
// result.
module edit_distance_engine (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  output logic                  req_ready,
  input  wire ede_pkg::ede_req_t req,
  output logic                  res_valid,
  input  wire logic             res_ready,
  output ede_pkg::ede_res_t     res
);

  localparam int N = ede_pkg::MAX_LEN;
  localparam int W = ede_pkg::COST_W;

  logic [W-1:0]      source_len;
  logic [W-1:0]      target_len;
  logic [W-1:0]      drain_cnt;
  logic              error_flag;
  ede_pkg::ede_link_t head;
  ede_pkg::ede_link_t link [N+1];
  logic [W-1:0]      cell_cost [N];
  logic              accept;
  logic              is_src;
  logic              is_tgt;
  logic              is_fin;
  logic              src_ok;
  logic              tgt_ok;
  logic [W-1:0]      last_cost;
  logic [ede_pkg::DIST_W-1:0] dist_sat;

  // Decode the request
  assign is_src = (req.req_type == ede_pkg::REQ_SOURCE);
  assign is_tgt = (req.req_type == ede_pkg::REQ_TARGET);
  assign is_fin = (req.req_type == ede_pkg::REQ_FINISH);
  assign src_ok = (target_len == '0) && (source_len < W'(N));
  assign tgt_ok = (target_len < W'(N));

  // Stall a finish until the row has drained and the result slot is free
  assign req_ready = !is_fin || ((drain_cnt == '0) && (!res_valid || res_ready));
  assign accept    = req_valid && req_ready;

  // Final cost: no target bytes means the distance is the source length
  assign last_cost = (target_len == '0) ? source_len : cell_cost[N-1];

  // Saturate to the distance field
  always_comb begin
    if ({{(32-W){1'b0}}, last_cost} > 32'(ede_pkg::DIST_MAX)) begin
      dist_sat = ede_pkg::DIST_W'(ede_pkg::DIST_MAX);
    end else begin
      dist_sat = ede_pkg::DIST_W'({{(32-W){1'b0}}, last_cost});
    end
  end

  // Lengths, error flag and drain counter
  always_ff @(posedge clk) begin
    if (rst) begin
      source_len <= '0;
      target_len <= '0;
      error_flag <= 1'b0;
      drain_cnt  <= '0;
    end else begin
      if (accept && is_tgt && tgt_ok) begin
        drain_cnt <= W'(N);
      end else if (drain_cnt != '0) begin
        drain_cnt <= drain_cnt - W'(1);
      end
      if (accept) begin
        if (is_fin) begin
          source_len <= '0;
          target_len <= '0;
          error_flag <= 1'b0;
        end else if (is_src) begin
          if (src_ok) begin
            source_len <= source_len + W'(1);
          end else begin
            error_flag <= 1'b1;
          end
        end else if (is_tgt) begin
          if (tgt_ok) begin
            target_len <= target_len + W'(1);
          end else begin
            error_flag <= 1'b1;
          end
        end
      end
    end
  end

  // Inject each target byte at the head of the row with column zero costs
  always_ff @(posedge clk) begin
    head.ch       <= req.char_in;
    head.new_cost <= target_len + W'(1);
    head.old_cost <= target_len;
    if (rst) begin
      head.valid <= 1'b0;
    end else begin
      head.valid <= accept && is_tgt && tgt_ok;
    end
  end

  assign link[0] = head;

  // Row of cells
  for (genvar i = 0; i < N; i++) begin : g_cell
    ede_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .clr      (accept && is_fin),
      .cell_idx (W'(i + 1)),
      .load_en  (accept && is_src && src_ok && (source_len == W'(i))),
      .load_char(req.char_in),
      .link_in  (link[i]),
      .link_out (link[i+1]),
      .cost     (cell_cost[i])
    );
  end

  // Result register
  always_ff @(posedge clk) begin
    if (accept && is_fin) begin
      res.distance <= dist_sat;
      res.error    <= error_flag;
    end
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept && is_fin) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ede_checker.sv
// Port-level checks for the edit distance engine, bound to the top level.
// Depends on ede_pkg and edit_distance_engine.
`timescale 1ns / 1ps
`default_nettype none

module ede_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              req_valid,
  input wire logic              req_ready,
  input wire ede_pkg::ede_req_t req,
  input wire logic              res_valid,
  input wire logic              res_ready,
  input wire ede_pkg::ede_res_t res
);

  // Hold a stalled result
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result changed while stalled");

  // Every accepted finish gives a result next cycle
  a_fin_res: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req.req_type == ede_pkg::REQ_FINISH) |=> res_valid)
    else $error("finish gave no result");

  // A new result only follows a finish
  a_res_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(req_valid && req_ready
                               && (req.req_type == ede_pkg::REQ_FINISH)))
    else $error("result without finish");

  // Distance never exceeds the longest string
  a_dist_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ({25'd0, res.distance} <= 32'(ede_pkg::MAX_LEN)))
    else $error("distance out of range");

endmodule

bind edit_distance_engine ede_checker u_ede_checker (
  .clk      (clk),
  .rst      (rst),
  .req_valid(req_valid),
  .req_ready(req_ready),
  .req      (req),
  .res_valid(res_valid),
  .res_ready(res_ready),
  .res      (res)
);

`default_nettype wire
